>>> design/lpht_pkg.sv
// Shared types, constants and hash multipliers of the linear probe hash table.
package lpht_pkg;

    localparam int TABLE_SLOTS = 1024;
    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W = SLOT_W + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] FMIX_MUL1 = 32'h85ebca6b;
    localparam logic [31:0] FMIX_MUL2 = 32'hc2b2ae35;

    localparam logic [2:0] MODE_LOOKUP = 3'd0;
    localparam logic [2:0] MODE_STORE = 3'd1;
    localparam logic [2:0] MODE_REMOVE = 3'd2;
    localparam logic [2:0] MODE_INHERIT = 3'd3;
    localparam logic [2:0] MODE_CLEAR = 3'd4;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [31:0] key;
        logic [31:0] parent_key;
        logic [63:0] entry_value;
    } cmd_t;

endpackage

>>> design/lpht_hash.sv
// Two-stage pipelined murmur3 finalizer that yields the home slot of a key.
module lpht_hash
(
    input  logic clk,
    input  logic rst_n,
    input  logic go,
    input  logic [31:0] key,
    output logic done,
    output lpht_pkg::slot_t slot
);

    logic [31:0] h1_reg;
    logic [31:0] h2_reg;
    logic [1:0] vld_reg;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;

    always_comb
    begin
        a = key ^ (key >> 16);
        b = h1_reg ^ (h1_reg >> 13);
        c = h2_reg ^ (h2_reg >> 16);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 2'b00;
        end
        else
        begin
            vld_reg <= {vld_reg[0], go};
        end
    end

    always_ff @(posedge clk)
    begin
        h1_reg <= a * lpht_pkg::FMIX_MUL1;
        h2_reg <= b * lpht_pkg::FMIX_MUL2;
    end

    assign done = vld_reg[1];
    assign slot = c[lpht_pkg::SLOT_W-1:0];

endmodule

>>> design/lpht_queue.sv
// Front end: accepts commands into a short queue toward the engine.
module lpht_queue
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  lpht_pkg::cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic avail,
    output lpht_pkg::cmd_t head
);

    lpht_pkg::cmd_t mem_reg [lpht_pkg::QUEUE_DEPTH];
    logic [lpht_pkg::QPTR_W-1:0] wr_reg;
    logic [lpht_pkg::QPTR_W-1:0] rd_reg;
    logic [lpht_pkg::QPTR_W:0] cnt_reg;

    assign full = (cnt_reg == (lpht_pkg::QPTR_W+1)'(lpht_pkg::QUEUE_DEPTH));
    assign avail = (cnt_reg != '0);
    assign head = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

>>> design/lpht_engine.sv
// Back end: probes, writes and shifts slots in the key and value memories.
module lpht_engine
(
    input  logic clk,
    input  logic rst_n,
    input  logic avail,
    input  lpht_pkg::cmd_t head,
    output logic pop,
    output logic busy_clear,
    output logic done,
    output logic [63:0] read_value,
    output logic found,
    output logic dropped
);

    localparam logic [3:0] ST_INIT = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_HASH = 4'd2;
    localparam logic [3:0] ST_RD = 4'd3;
    localparam logic [3:0] ST_CHK = 4'd4;
    localparam logic [3:0] ST_SHRD = 4'd5;
    localparam logic [3:0] ST_SHHASH = 4'd6;
    localparam logic [3:0] ST_DONE = 4'd8;
    localparam logic [3:0] ST_VRD = 4'd9;

    localparam logic [1:0] PH_FIND = 2'd0;
    localparam logic [1:0] PH_PUT = 2'd1;
    localparam logic [1:0] PH_BOOT = 2'd3;

    logic [31:0] key_mem [lpht_pkg::TABLE_SLOTS];
    logic [63:0] val_mem [lpht_pkg::TABLE_SLOTS];

    logic [3:0] state_reg;
    logic [3:0] state_next;
    lpht_pkg::cmd_t cmd_reg;
    logic [1:0] phase_reg;
    lpht_pkg::slot_t pos_reg;
    lpht_pkg::slot_t base_reg;
    lpht_pkg::slot_t hole_reg;
    logic [lpht_pkg::CNT_W-1:0] cnt_reg;
    logic [31:0] probe_key_reg;
    logic [31:0] rkey_reg;
    logic [63:0] rval_reg;
    logic [63:0] value_reg;
    logic found_reg;
    logic dropped_reg;
    logic done_reg;

    logic hash_go;
    logic [31:0] hash_key;
    logic hash_done;
    lpht_pkg::slot_t hash_slot;

    logic key_we;
    lpht_pkg::slot_t key_wa;
    logic [31:0] key_wd;
    logic val_we;
    lpht_pkg::slot_t val_wa;
    logic [63:0] val_wd;
    lpht_pkg::slot_t rd_addr;
    lpht_pkg::slot_t nx;
    lpht_pkg::slot_t d_hole;
    lpht_pkg::slot_t d_nx;

    lpht_hash u_hash
    (
        .clk(clk),
        .rst_n(rst_n),
        .go(hash_go),
        .key(hash_key),
        .done(hash_done),
        .slot(hash_slot)
    );

    assign nx = hole_reg + 1'b1;
    assign d_hole = hole_reg - hash_slot;
    assign d_nx = nx - hash_slot;
    assign pop = (state_reg == ST_IDLE) && avail;
    assign busy_clear = (state_reg == ST_INIT);
    assign done = done_reg;
    assign read_value = value_reg;
    assign found = found_reg;
    assign dropped = dropped_reg;

    always_comb
    begin
        hash_go = 1'b0;
        hash_key = probe_key_reg;
        rd_addr = pos_reg;
        key_we = 1'b0;
        key_wa = pos_reg;
        key_wd = probe_key_reg;
        val_we = 1'b0;
        val_wa = pos_reg;
        val_wd = value_reg;
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                key_we = 1'b1;
                key_wa = cnt_reg[lpht_pkg::SLOT_W-1:0];
                key_wd = '0;
                if (cnt_reg == lpht_pkg::CNT_W'(lpht_pkg::TABLE_SLOTS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_IDLE:
            begin
                if (avail)
                begin
                    if (head.mode == lpht_pkg::MODE_CLEAR)
                    begin
                        state_next = ST_INIT;
                    end
                    else if ((head.mode == lpht_pkg::MODE_LOOKUP
                              || head.mode == lpht_pkg::MODE_STORE
                              || head.mode == lpht_pkg::MODE_REMOVE)
                             && head.key != '0)
                    begin
                        hash_go = 1'b1;
                        hash_key = head.key;
                        state_next = ST_HASH;
                    end
                    else if (head.mode == lpht_pkg::MODE_INHERIT && head.parent_key != '0)
                    begin
                        hash_go = 1'b1;
                        hash_key = head.parent_key;
                        state_next = ST_HASH;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_HASH:
            begin
                rd_addr = hash_slot;
                if (hash_done)
                begin
                    state_next = ST_CHK;
                end
            end
            ST_RD:
            begin
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (rkey_reg == probe_key_reg)
                begin
                    if (phase_reg == PH_PUT)
                    begin
                        val_we = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (cmd_reg.mode == lpht_pkg::MODE_REMOVE)
                    begin
                        rd_addr = pos_reg + 1'b1;
                        state_next = ST_SHRD;
                    end
                    else
                    begin
                        state_next = ST_VRD;
                    end
                end
                else if (rkey_reg == '0)
                begin
                    if (phase_reg == PH_PUT)
                    begin
                        key_we = 1'b1;
                        val_we = 1'b1;
                    end
                    state_next = ST_DONE;
                end
                else if (cnt_reg == lpht_pkg::CNT_W'(lpht_pkg::TABLE_SLOTS - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_addr = pos_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_VRD:
            begin
                if (cmd_reg.mode == lpht_pkg::MODE_INHERIT && rval_reg != '0
                    && cmd_reg.key != '0)
                begin
                    hash_go = 1'b1;
                    hash_key = cmd_reg.key;
                    state_next = ST_HASH;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SHRD:
            begin
                rd_addr = nx;
                if (rkey_reg == '0 || cnt_reg == lpht_pkg::CNT_W'(lpht_pkg::TABLE_SLOTS))
                begin
                    key_we = 1'b1;
                    key_wa = hole_reg;
                    key_wd = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    hash_go = 1'b1;
                    hash_key = rkey_reg;
                    state_next = ST_SHHASH;
                end
            end
            ST_SHHASH:
            begin
                rd_addr = nx;
                if (hash_done)
                begin
                    if (d_hole < d_nx)
                    begin
                        key_we = 1'b1;
                        key_wa = hole_reg;
                        key_wd = rkey_reg;
                        val_we = 1'b1;
                        val_wa = hole_reg;
                        val_wd = rval_reg;
                        rd_addr = nx + 1'b1;
                        state_next = ST_SHRD;
                    end
                    else
                    begin
                        key_we = 1'b1;
                        key_wa = hole_reg;
                        key_wd = '0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rkey_reg <= key_mem[rd_addr];
        rval_reg <= val_mem[rd_addr];
        if (key_we)
        begin
            key_mem[key_wa] <= key_wd;
        end
        if (val_we)
        begin
            val_mem[val_wa] <= val_wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            cnt_reg <= '0;
            done_reg <= 1'b0;
            phase_reg <= PH_BOOT;
            found_reg <= 1'b0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= (state_reg == ST_DONE) && (phase_reg != PH_BOOT);
            case (state_reg)
                ST_INIT:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    phase_reg <= PH_FIND;
                    found_reg <= 1'b0;
                    dropped_reg <= 1'b0;
                    if (avail)
                    begin
                        cmd_reg <= head;
                        value_reg <= '0;
                        probe_key_reg <= (head.mode == lpht_pkg::MODE_INHERIT)
                                         ? head.parent_key : head.key;
                        if (head.mode == lpht_pkg::MODE_STORE)
                        begin
                            phase_reg <= PH_PUT;
                            value_reg <= head.entry_value;
                        end
                    end
                end
                ST_HASH:
                begin
                    pos_reg <= hash_slot;
                    cnt_reg <= '0;
                end
                ST_CHK:
                begin
                    if (rkey_reg == probe_key_reg)
                    begin
                        if (phase_reg == PH_PUT)
                        begin
                            found_reg <= 1'b1;
                        end
                        else
                        begin
                            found_reg <= 1'b1;
                            hole_reg <= pos_reg;
                            cnt_reg <= '0;
                        end
                    end
                    else if (rkey_reg != '0)
                    begin
                        if (cnt_reg == lpht_pkg::CNT_W'(lpht_pkg::TABLE_SLOTS - 1))
                        begin
                            dropped_reg <= (phase_reg == PH_PUT);
                        end
                        pos_reg <= pos_reg + 1'b1;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_VRD:
                begin
                    value_reg <= rval_reg;
                    if (cmd_reg.mode == lpht_pkg::MODE_INHERIT)
                    begin
                        phase_reg <= PH_PUT;
                        probe_key_reg <= cmd_reg.key;
                    end
                end
                ST_SHRD:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ST_SHHASH:
                begin
                    if (hash_done && d_hole < d_nx)
                    begin
                        hole_reg <= nx;
                    end
                end
                ST_DONE:
                begin
                    if (cmd_reg.mode != lpht_pkg::MODE_LOOKUP
                        && cmd_reg.mode != lpht_pkg::MODE_INHERIT)
                    begin
                        value_reg <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && found && dropped) |-> (cmd_reg.mode == lpht_pkg::MODE_INHERIT))
        else $error("found and dropped together outside inherit");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHK) |-> (cnt_reg <= lpht_pkg::CNT_W'(lpht_pkg::TABLE_SLOTS)))
        else $error("probe count overran the table");
    assert property (@(posedge clk) disable iff (!rst_n) pop |=> (state_reg != ST_IDLE))
        else $error("engine stayed idle after taking a command");

endmodule

>>> design/linear_probe_hash_table_top.sv
// Top level of the linear probe hash table.
// One command is taken when start is high and busy is low; exactly one result
// follows, marked by a one-cycle strobe that the receiver must take, since it
// cannot stall. Commands wait in a two-entry queue, and busy is high only while
// that queue is full. A command hashes its key to a home slot in the two-stage
// murmur3 pipeline, then reads slots in turn through the registered read of the
// key and value memories until it finds the key, finds an empty slot or has
// probed every slot. A remove then shifts later entries back into the hole,
// hashing each again, and an inherit runs a lookup of the parent key and then,
// if the parent's value is nonzero, a store. After reset and after each clear
// command the engine sweeps all 1024 key slots, one per cycle, before new work
// starts.
module linear_probe_hash_table_top
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  logic [2:0] mode,
    input  logic [31:0] key,
    input  logic [31:0] parent_key,
    input  logic [63:0] entry_value,
    output logic strobe,
    output logic [63:0] read_value,
    output logic found,
    output logic dropped
);

    lpht_pkg::cmd_t in_cmd;
    lpht_pkg::cmd_t head;
    logic full;
    logic avail;
    logic pop;
    logic clearing;

    assign in_cmd = '{mode: mode, key: key, parent_key: parent_key, entry_value: entry_value};
    assign busy = full;

    lpht_queue u_queue
    (
        .clk(clk),
        .rst_n(rst_n),
        .push(start && !full),
        .push_cmd(in_cmd),
        .full(full),
        .pop(pop),
        .avail(avail),
        .head(head)
    );

    lpht_engine u_engine
    (
        .clk(clk),
        .rst_n(rst_n),
        .avail(avail && !clearing),
        .head(head),
        .pop(pop),
        .busy_clear(clearing),
        .done(strobe),
        .read_value(read_value),
        .found(found),
        .dropped(dropped)
    );

endmodule
